FILE: hw/rtl/ccr_pkg.sv
// Shared types and constants for the circle pair collision resolve pipeline.
package ccr_pkg;

  localparam int POS_W  = 28;
  localparam int VEL_W  = 27;
  localparam int RAD_W  = 25;
  localparam int SUM_W  = 26;  // radius sum
  localparam int MAG_W  = 29;  // magnitude of a centre difference
  localparam int SQ_W   = 52;  // squared distance seen by the root unit
  localparam int ROOT_W = 26;  // integer root of SQ_W bits

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam logic [POS_W-1:0] WIDTH_RST  = 28'd52428800;
  localparam logic [POS_W-1:0] HEIGHT_RST = 28'd39321600;

  typedef struct packed {
    logic        [POS_W-1:0] x1;
    logic        [POS_W-1:0] y1;
    logic signed [VEL_W-1:0] vx1;
    logic signed [VEL_W-1:0] vy1;
    logic        [RAD_W-1:0] r1;
    logic        [POS_W-1:0] x2;
    logic        [POS_W-1:0] y2;
    logic signed [VEL_W-1:0] vx2;
    logic signed [VEL_W-1:0] vy2;
    logic        [RAD_W-1:0] r2;
  } pair_t;

  // travels beside the root unit
  typedef struct packed {
    pair_t             p;
    logic              touched;
    logic [SUM_W-1:0]  s;
    logic [MAG_W-1:0]  ax;
    logic [MAG_W-1:0]  ay;
    logic              sx;
    logic              sy;
  } sq_side_t;

  // travels out of the normal divider
  typedef struct packed {
    pair_t             p;
    logic              touched;
    logic [SUM_W-1:0]  s;
    logic [ROOT_W-1:0] dlen;
  } nd_side_t;

endpackage

FILE: hw/rtl/circle_pair_collision_resolve_unit.sv
// Top level of the circle pair collision resolve pipeline.
// Resolves one circle pair per clock: touch test, unit normal, half-overlap push-apart,
// container clamp and an equal-mass impulse with restitution 0.7, all in fixed point
// with FRAC_BITS fraction bits. From transfer in to result a pair passes 4 front stages,
// the 26-stage square root, the FRAC_BITS + 1 stage normal divider and 9 back stages.
// A new pair is taken every cycle; when the result is not taken the whole pipeline holds.
module circle_pair_collision_resolve_unit import ccr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // first_x, first_y, first_vx, first_vy, first_radius,
  // second_x, second_y, second_vx, second_vy, second_radius, zero pad
  input  logic [271:0]         in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // new_first_x, new_first_y, new_first_vx, new_first_vy,
  // new_second_x, new_second_y, new_second_vx, new_second_vy, zero pad
  output logic [223:0]         out_tdata,
  // touched
  output logic                 out_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data
);

  localparam int N_W    = FRAC_BITS + 2;
  localparam int OVL_W  = SUM_W + 1;
  localparam int DU_W   = VEL_W + 1;
  localparam int CXP_W  = N_W + OVL_W;
  localparam int CX_W   = CXP_W - FRAC_BITS - 1;
  localparam int QP_W   = N_W + DU_W;
  localparam int Q_W    = QP_W + 1;
  localparam int WQ_W   = Q_W - FRAC_BITS;
  localparam int NWQ_W  = WQ_W + 1;
  localparam int CR_W   = FRAC_BITS + 3;
  localparam int JP_W   = NWQ_W + CR_W;
  localparam int J_W    = JP_W - FRAC_BITS - 1;
  localparam int KP_W   = N_W + J_W;
  localparam int K_W    = KP_W - FRAC_BITS;
  localparam int P_W    = POS_W + 2;
  localparam int HI_W   = POS_W + 1;
  localparam int ONE_I  = 1 << FRAC_BITS;
  localparam int REST_I = (7 * ONE_I + 5) / 10;

  localparam logic signed [CR_W-1:0]  ONE_REST = CR_W'(ONE_I + REST_I);
  localparam logic signed [CXP_W-1:0] CX_RND   = CXP_W'((1 << (FRAC_BITS + 1)) - 1);
  localparam logic signed [Q_W-1:0]   Q_RND    = Q_W'(ONE_I - 1);
  localparam logic signed [KP_W-1:0]  K_RND    = KP_W'(ONE_I - 1);

  function automatic logic [POS_W-1:0] clamp_pos(input logic signed [P_W-1:0] p,
                                                 input logic signed [HI_W-1:0] hi,
                                                 input logic [RAD_W-1:0] r);
    logic signed [P_W-1:0] t;
    logic signed [P_W-1:0] rs;
    rs = $signed({5'b0, r});
    t  = (p > P_W'(hi)) ? P_W'(hi) : p;
    if (t < rs) t = rs;
    return t[POS_W-1:0];
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [K_W:0] v);
    if (v > (K_W+1)'(67108863)) return 27'sh3FFFFFF;
    if (v < -(K_W+1)'(67108864)) return 27'sh4000000;
    return v[VEL_W-1:0];
  endfunction

  logic [POS_W-1:0] width_r, height_r;
  logic             en;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pair_t in_p;
  assign in_p.x1  = in_tdata[27:0];
  assign in_p.y1  = in_tdata[55:28];
  assign in_p.vx1 = in_tdata[82:56];
  assign in_p.vy1 = in_tdata[109:83];
  assign in_p.r1  = in_tdata[134:110];
  assign in_p.x2  = in_tdata[162:135];
  assign in_p.y2  = in_tdata[190:163];
  assign in_p.vx2 = in_tdata[217:191];
  assign in_p.vy2 = in_tdata[244:218];
  assign in_p.r2  = in_tdata[269:245];

  // front stages
  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r;
  pair_t a_p_r, b_p_r, c_p_r;
  logic signed [MAG_W-1:0] b_dx_r, b_dy_r;
  logic [SUM_W-1:0] b_s_r, c_s_r;
  logic [2*MAG_W-2:0] c_dx2_r, c_dy2_r;
  logic [SQ_W-1:0] c_ssq_r, d_rad_r;
  logic [MAG_W-1:0] c_ax_r, c_ay_r;
  logic c_sx_r, c_sy_r;
  sq_side_t d_side_r;

  logic signed [2*MAG_W-1:0] dx2_w, dy2_w;
  logic signed [MAG_W-1:0]   ndx_w, ndy_w;
  logic [2*MAG_W-1:0]        dsq_w;

  assign dx2_w = b_dx_r * b_dx_r;
  assign dy2_w = b_dy_r * b_dy_r;
  assign ndx_w = -b_dx_r;
  assign ndy_w = -b_dy_r;
  assign dsq_w = {1'b0, c_dx2_r} + {1'b0, c_dy2_r};

  // root and divider
  logic            sq_vld, nd_vld;
  logic [ROOT_W-1:0] sq_root;
  sq_side_t        sq_side;
  logic signed [N_W-1:0] nd_nx, nd_ny;
  nd_side_t        nd_side;

  ccr_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d_vld_r),
    .in_rad   (d_rad_r),
    .in_side  (d_side_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  ccr_ndiv #(.FRAC_BITS(FRAC_BITS)) u_ndiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sq_vld),
    .in_dist  (sq_root),
    .in_side  (sq_side),
    .out_vld  (nd_vld),
    .out_nx   (nd_nx),
    .out_ny   (nd_ny),
    .out_side (nd_side)
  );

  // back stages
  logic e_vld_r, f_vld_r, g_vld_r, h_vld_r, i_vld_r, j_vld_r, k_vld_r, l_vld_r;
  pair_t e_p_r, f_p_r, g_p_r, h_p_r, i_p_r, j_p_r, k_p_r, l_p_r;
  logic e_t_r, f_t_r, g_t_r, h_t_r, i_t_r, j_t_r, k_t_r, l_t_r;
  logic signed [N_W-1:0] e_nx_r, e_ny_r, f_nx_r, f_ny_r, g_nx_r, g_ny_r;
  logic signed [N_W-1:0] h_nx_r, h_ny_r, i_nx_r, i_ny_r, j_nx_r, j_ny_r;
  logic signed [OVL_W-1:0] e_ovl_r;
  logic signed [DU_W-1:0]  e_du_r, e_dv_r;
  logic signed [CXP_W-1:0] f_cxp_r, f_cyp_r;
  logic signed [QP_W-1:0]  f_qx_r, f_qy_r;
  logic f_ovp_r;
  logic signed [CX_W-1:0]  g_cx_r, g_cy_r;
  logic signed [Q_W-1:0]   g_q_r;
  logic signed [P_W-1:0]   h_px1_r, h_py1_r, h_px2_r, h_py2_r;
  logic signed [HI_W-1:0]  h_hx1_r, h_hy1_r, h_hx2_r, h_hy2_r;
  logic signed [WQ_W-1:0]  h_wq_r;
  logic h_qn_r, i_qn_r, j_qn_r, k_qn_r, l_qn_r;
  logic [POS_W-1:0] i_x1_r, i_y1_r, i_x2_r, i_y2_r, j_x1_r, j_y1_r, j_x2_r, j_y2_r;
  logic [POS_W-1:0] k_x1_r, k_y1_r, k_x2_r, k_y2_r, l_x1_r, l_y1_r, l_x2_r, l_y2_r;
  logic signed [JP_W-1:0] i_jp_r;
  logic signed [J_W-1:0]  j_j_r;
  logic signed [KP_W-1:0] k_kxp_r, k_kyp_r;
  logic signed [K_W-1:0]  l_kx_r, l_ky_r;

  logic signed [CXP_W-1:0] cxa_w, cya_w;
  logic signed [Q_W-1:0]   q_w, qa_w;
  logic signed [NWQ_W-1:0] nwq_w;
  logic signed [KP_W-1:0]  kxa_w, kya_w;

  assign cxa_w = f_cxp_r + (f_cxp_r[CXP_W-1] ? CX_RND : CXP_W'(0));
  assign cya_w = f_cyp_r + (f_cyp_r[CXP_W-1] ? CX_RND : CXP_W'(0));
  assign q_w   = g_q_r;
  assign qa_w  = q_w + (q_w[Q_W-1] ? Q_RND : Q_W'(0));
  assign nwq_w = -$signed({h_wq_r[WQ_W-1], h_wq_r});
  assign kxa_w = k_kxp_r + (k_kxp_r[KP_W-1] ? K_RND : KP_W'(0));
  assign kya_w = k_kyp_r + (k_kyp_r[KP_W-1] ? K_RND : KP_W'(0));

  // output stage
  logic out_vld_r, out_t_r;
  logic [POS_W-1:0] o_x1_r, o_y1_r, o_x2_r, o_y2_r;
  logic signed [VEL_W-1:0] o_vx1_r, o_vy1_r, o_vx2_r, o_vy2_r;
  logic imp;

  assign imp = l_t_r && l_qn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      e_vld_r   <= 1'b0;
      f_vld_r   <= 1'b0;
      g_vld_r   <= 1'b0;
      h_vld_r   <= 1'b0;
      i_vld_r   <= 1'b0;
      j_vld_r   <= 1'b0;
      k_vld_r   <= 1'b0;
      l_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r   <= in_tvalid;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      d_vld_r   <= c_vld_r;
      e_vld_r   <= nd_vld;
      f_vld_r   <= e_vld_r;
      g_vld_r   <= f_vld_r;
      h_vld_r   <= g_vld_r;
      i_vld_r   <= h_vld_r;
      j_vld_r   <= i_vld_r;
      k_vld_r   <= j_vld_r;
      l_vld_r   <= k_vld_r;
      out_vld_r <= l_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p_r  <= in_p;

      b_p_r  <= a_p_r;
      b_dx_r <= $signed({1'b0, a_p_r.x2}) - $signed({1'b0, a_p_r.x1});
      b_dy_r <= $signed({1'b0, a_p_r.y2}) - $signed({1'b0, a_p_r.y1});
      b_s_r  <= {1'b0, a_p_r.r1} + {1'b0, a_p_r.r2};

      c_p_r   <= b_p_r;
      c_s_r   <= b_s_r;
      c_dx2_r <= dx2_w[2*MAG_W-2:0];
      c_dy2_r <= dy2_w[2*MAG_W-2:0];
      c_ssq_r <= b_s_r * b_s_r;
      c_ax_r  <= b_dx_r[MAG_W-1] ? ndx_w : b_dx_r;
      c_ay_r  <= b_dy_r[MAG_W-1] ? ndy_w : b_dy_r;
      c_sx_r  <= b_dx_r[MAG_W-1];
      c_sy_r  <= b_dy_r[MAG_W-1];

      d_rad_r          <= dsq_w[SQ_W-1:0];
      d_side_r.p       <= c_p_r;
      d_side_r.touched <= dsq_w <= (2*MAG_W)'(c_ssq_r);
      d_side_r.s       <= c_s_r;
      d_side_r.ax      <= c_ax_r;
      d_side_r.ay      <= c_ay_r;
      d_side_r.sx      <= c_sx_r;
      d_side_r.sy      <= c_sy_r;

      e_p_r   <= nd_side.p;
      e_t_r   <= nd_side.touched;
      e_nx_r  <= nd_nx;
      e_ny_r  <= nd_ny;
      e_ovl_r <= $signed({1'b0, nd_side.s}) - $signed({1'b0, nd_side.dlen});
      e_du_r  <= $signed({nd_side.p.vx2[VEL_W-1], nd_side.p.vx2})
               - $signed({nd_side.p.vx1[VEL_W-1], nd_side.p.vx1});
      e_dv_r  <= $signed({nd_side.p.vy2[VEL_W-1], nd_side.p.vy2})
               - $signed({nd_side.p.vy1[VEL_W-1], nd_side.p.vy1});

      f_p_r   <= e_p_r;
      f_t_r   <= e_t_r;
      f_nx_r  <= e_nx_r;
      f_ny_r  <= e_ny_r;
      f_cxp_r <= e_nx_r * e_ovl_r;
      f_cyp_r <= e_ny_r * e_ovl_r;
      f_qx_r  <= e_du_r * e_nx_r;
      f_qy_r  <= e_dv_r * e_ny_r;
      f_ovp_r <= e_ovl_r > 0;

      // half-overlap correction, truncated toward zero
      g_p_r  <= f_p_r;
      g_t_r  <= f_t_r;
      g_nx_r <= f_nx_r;
      g_ny_r <= f_ny_r;
      g_cx_r <= f_ovp_r ? $signed(cxa_w[CXP_W-1:FRAC_BITS+1]) : CX_W'(0);
      g_cy_r <= f_ovp_r ? $signed(cya_w[CXP_W-1:FRAC_BITS+1]) : CX_W'(0);
      g_q_r  <= f_qx_r + f_qy_r;

      h_p_r   <= g_p_r;
      h_t_r   <= g_t_r;
      h_nx_r  <= g_nx_r;
      h_ny_r  <= g_ny_r;
      h_px1_r <= $signed({2'b0, g_p_r.x1}) - g_cx_r;
      h_py1_r <= $signed({2'b0, g_p_r.y1}) - g_cy_r;
      h_px2_r <= $signed({2'b0, g_p_r.x2}) + g_cx_r;
      h_py2_r <= $signed({2'b0, g_p_r.y2}) + g_cy_r;
      h_hx1_r <= $signed({1'b0, width_r})  - $signed({4'b0, g_p_r.r1});
      h_hy1_r <= $signed({1'b0, height_r}) - $signed({4'b0, g_p_r.r1});
      h_hx2_r <= $signed({1'b0, width_r})  - $signed({4'b0, g_p_r.r2});
      h_hy2_r <= $signed({1'b0, height_r}) - $signed({4'b0, g_p_r.r2});
      h_wq_r  <= $signed(qa_w[Q_W-1:FRAC_BITS]);
      h_qn_r  <= q_w[Q_W-1];

      i_p_r  <= h_p_r;
      i_t_r  <= h_t_r;
      i_nx_r <= h_nx_r;
      i_ny_r <= h_ny_r;
      i_qn_r <= h_qn_r;
      i_x1_r <= clamp_pos(h_px1_r, h_hx1_r, h_p_r.r1);
      i_y1_r <= clamp_pos(h_py1_r, h_hy1_r, h_p_r.r1);
      i_x2_r <= clamp_pos(h_px2_r, h_hx2_r, h_p_r.r2);
      i_y2_r <= clamp_pos(h_py2_r, h_hy2_r, h_p_r.r2);
      i_jp_r <= nwq_w * ONE_REST;

      // impulse is never negative where it is applied, so a plain shift truncates
      j_p_r  <= i_p_r;
      j_t_r  <= i_t_r;
      j_nx_r <= i_nx_r;
      j_ny_r <= i_ny_r;
      j_qn_r <= i_qn_r;
      j_x1_r <= i_x1_r;
      j_y1_r <= i_y1_r;
      j_x2_r <= i_x2_r;
      j_y2_r <= i_y2_r;
      j_j_r  <= $signed(i_jp_r[JP_W-1:FRAC_BITS+1]);

      k_p_r   <= j_p_r;
      k_t_r   <= j_t_r;
      k_qn_r  <= j_qn_r;
      k_x1_r  <= j_x1_r;
      k_y1_r  <= j_y1_r;
      k_x2_r  <= j_x2_r;
      k_y2_r  <= j_y2_r;
      k_kxp_r <= j_nx_r * j_j_r;
      k_kyp_r <= j_ny_r * j_j_r;

      l_p_r  <= k_p_r;
      l_t_r  <= k_t_r;
      l_qn_r <= k_qn_r;
      l_x1_r <= k_x1_r;
      l_y1_r <= k_y1_r;
      l_x2_r <= k_x2_r;
      l_y2_r <= k_y2_r;
      l_kx_r <= $signed(kxa_w[KP_W-1:FRAC_BITS]);
      l_ky_r <= $signed(kya_w[KP_W-1:FRAC_BITS]);

      // untouched pairs pass their inputs through
      out_t_r <= l_t_r;
      o_x1_r  <= l_t_r ? l_x1_r : l_p_r.x1;
      o_y1_r  <= l_t_r ? l_y1_r : l_p_r.y1;
      o_x2_r  <= l_t_r ? l_x2_r : l_p_r.x2;
      o_y2_r  <= l_t_r ? l_y2_r : l_p_r.y2;
      o_vx1_r <= imp ? sat_vel((K_W+1)'(l_p_r.vx1) - (K_W+1)'(l_kx_r)) : l_p_r.vx1;
      o_vy1_r <= imp ? sat_vel((K_W+1)'(l_p_r.vy1) - (K_W+1)'(l_ky_r)) : l_p_r.vy1;
      o_vx2_r <= imp ? sat_vel((K_W+1)'(l_p_r.vx2) + (K_W+1)'(l_kx_r)) : l_p_r.vx2;
      o_vy2_r <= imp ? sat_vel((K_W+1)'(l_p_r.vy2) + (K_W+1)'(l_ky_r)) : l_p_r.vy2;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_t_r;
  assign out_tdata  = {4'b0, o_vy2_r, o_vx2_r, o_y2_r, o_x2_r,
                       o_vy1_r, o_vx1_r, o_y1_r, o_x1_r};

endmodule

FILE: hw/rtl/ccr_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module ccr_isqrt import ccr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [SQ_W-1:0]   in_rad,
  input  sq_side_t          in_side,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root,
  output sq_side_t          out_side
);

  logic [SQ_W-1:0] v_r   [ROOT_W];
  logic [SQ_W-1:0] res_r [ROOT_W];
  logic            vld_r [ROOT_W];
  sq_side_t        side_r[ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - i));
    logic [SQ_W-1:0] v_c, res_c, sum_c, v_nxt, res_nxt;
    logic            vld_c;
    sq_side_t        side_c;

    if (i == 0) begin : g_first
      assign v_c    = in_rad;
      assign res_c  = '0;
      assign vld_c  = in_vld;
      assign side_c = in_side;
    end else begin : g_next
      assign v_c    = v_r[i-1];
      assign res_c  = res_r[i-1];
      assign vld_c  = vld_r[i-1];
      assign side_c = side_r[i-1];
    end

    always_comb begin
      sum_c = res_c + BIT;
      if (v_c >= sum_c) begin
        v_nxt   = v_c - sum_c;
        res_nxt = (res_c >> 1) + BIT;
      end else begin
        v_nxt   = v_c;
        res_nxt = res_c >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[i]    <= v_nxt;
        res_r[i]  <= res_nxt;
        side_r[i] <= side_c;
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = res_r[ROOT_W-1][ROOT_W-1:0];
  assign out_side = side_r[ROOT_W-1];

endmodule

FILE: hw/rtl/ccr_ndiv.sv
// Pipelined restoring divider forming the unit normal (dx, dy) / dist.
module ccr_ndiv import ccr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [ROOT_W-1:0]         in_dist,
  input  sq_side_t                  in_side,
  output logic                      out_vld,
  output logic signed [FRAC_BITS+1:0] out_nx,
  output logic signed [FRAC_BITS+1:0] out_ny,
  output nd_side_t                  out_side
);

  localparam int STEPS = FRAC_BITS + 1;
  localparam logic signed [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;

  logic [MAG_W-1:0]  remx_r[STEPS];
  logic [MAG_W-1:0]  remy_r[STEPS];
  logic [STEPS-1:0]  qx_r  [STEPS];
  logic [STEPS-1:0]  qy_r  [STEPS];
  logic [ROOT_W-1:0] dist_r[STEPS];
  logic              vld_r [STEPS];
  sq_side_t          side_r[STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [MAG_W-1:0]  tx_c, ty_c, div_c;
    logic [STEPS-1:0]  qx_c, qy_c;
    logic [ROOT_W-1:0] dist_c;
    logic              vld_c, gex, gey;
    sq_side_t          side_c;

    if (i == 0) begin : g_first
      assign tx_c   = in_side.ax;
      assign ty_c   = in_side.ay;
      assign qx_c   = '0;
      assign qy_c   = '0;
      assign dist_c = in_dist;
      assign vld_c  = in_vld;
      assign side_c = in_side;
    end else begin : g_next
      assign tx_c   = {remx_r[i-1][MAG_W-2:0], 1'b0};
      assign ty_c   = {remy_r[i-1][MAG_W-2:0], 1'b0};
      assign qx_c   = qx_r[i-1];
      assign qy_c   = qy_r[i-1];
      assign dist_c = dist_r[i-1];
      assign vld_c  = vld_r[i-1];
      assign side_c = side_r[i-1];
    end

    assign div_c = MAG_W'(dist_c);
    assign gex   = tx_c >= div_c;
    assign gey   = ty_c >= div_c;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remx_r[i] <= gex ? tx_c - div_c : tx_c;
        remy_r[i] <= gey ? ty_c - div_c : ty_c;
        qx_r[i]   <= {qx_c[STEPS-2:0], gex};
        qy_r[i]   <= {qy_c[STEPS-2:0], gey};
        dist_r[i] <= dist_c;
        side_r[i] <= side_c;
      end
    end
  end

  logic signed [FRAC_BITS+1:0] magx, magy;
  logic                        dzero;

  assign magx  = $signed({1'b0, qx_r[STEPS-1]});
  assign magy  = $signed({1'b0, qy_r[STEPS-1]});
  assign dzero = dist_r[STEPS-1] == '0;

  // coincident centres take the normal (1,0)
  assign out_nx = dzero ? ONE : (side_r[STEPS-1].sx ? -magx : magx);
  assign out_ny = dzero ? '0  : (side_r[STEPS-1].sy ? -magy : magy);

  assign out_vld          = vld_r[STEPS-1];
  assign out_side.p       = side_r[STEPS-1].p;
  assign out_side.touched = side_r[STEPS-1].touched;
  assign out_side.s       = side_r[STEPS-1].s;
  assign out_side.dlen    = dist_r[STEPS-1];

endmodule
